// ----- rtl/she_pkg.sv -----
// Package for the spherical-harmonic basis evaluator: types, widths, arithmetic helpers.
`default_nettype none

package she_pkg;

    localparam int DIR_W  = 16;    // Q1.15 direction components
    localparam int VAL_W  = 24;    // Q7.16 result
    localparam int IDX_W  = 4;     // coefficient index field
    localparam int CFG_W  = 3;     // bands_in_use
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam int MAX_BANDS_DEF = 4;
    localparam logic [CFG_W-1:0] BANDS_RESET = 3'd3;
    localparam logic REG_BANDS = 1'b0;

    // internal widths, sized for up to eight bands
    localparam int P_W    = 40;             // Legendre term, Q.16
    localparam int CS_W   = 24;             // (x+iy)^m terms, Q.15
    localparam int CSP_W  = DIR_W + CS_W;   // x*c products
    localparam int PROD_W = DIR_W + P_W;    // z*p1
    localparam int NUM_W  = 62;             // weighted recurrence numerator
    localparam int U_W    = 48;             // dividend after the 2^15 scale
    localparam int REM_W  = 3;              // divisor is at most seven
    localparam int CHUNK  = 8;
    localparam int NCHUNK = U_W / CHUNK;
    localparam int MUL_W  = P_W + CS_W;
    localparam int RND_W  = MUL_W + 1;
    localparam int PH     = NCHUNK + 7;     // stages per band row

    localparam int RCP_W  = 17;             // reciprocal of the divisor, Q.16
    localparam int DV_W   = REM_W + CHUNK;  // partial dividend {rem, byte}
    localparam int DP_W   = DV_W + RCP_W;

    localparam int VAL_MAX = 8388607;
    localparam int VAL_MIN = -8388608;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } she_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]        coef_index;
        logic signed [VAL_W-1:0] coef_value;
        logic                    last_coef;
    } she_out_t;

    // sectoral start P(m,m) = prod(1-2k), Q.16
    function automatic logic signed [P_W-1:0] pmm_q16(input int m);
        logic signed [P_W-1:0] acc;
        acc = P_W'(65536);
        for (int k = 1; k <= m; k++) begin
            acc = acc * P_W'(1 - 2 * k);
        end
        return acc;
    endfunction

    // shift right by 15, round to nearest, ties away from zero
    function automatic logic signed [MUL_W-1:0] rnd15(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] r;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        r = (mag + RND_W'(16384)) >> 15;
        return v[RND_W-1] ? -$signed(MUL_W'(r)) : $signed(MUL_W'(r));
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [MUL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > $signed(MUL_W'(VAL_MAX))) begin
            r = VAL_W'(VAL_MAX);
        end else if (v < $signed(MUL_W'(VAL_MIN))) begin
            r = VAL_W'(VAL_MIN);
        end else begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

    // ceil(2^16 / d); exact quotient for partial dividends below 2^11
    function automatic logic [RCP_W-1:0] recip16(input logic [REM_W-1:0] d);
        logic [RCP_W-1:0] r;
        unique case (d)
            3'd0: r = '0;
            3'd1: r = RCP_W'(65536);
            3'd2: r = RCP_W'(32768);
            3'd3: r = RCP_W'(21846);
            3'd4: r = RCP_W'(16384);
            3'd5: r = RCP_W'(13108);
            3'd6: r = RCP_W'(10923);
            3'd7: r = RCP_W'(9363);
        endcase
        return r;
    endfunction

    // one quotient byte by reciprocal multiplication; returns {rem, quotient byte}
    function automatic logic [REM_W+CHUNK-1:0] div_chunk(
        input logic [REM_W-1:0] rem_in,
        input logic [CHUNK-1:0] dig,
        input logic [REM_W-1:0] dvs
    );
        logic [DV_W-1:0]  v;
        logic [DP_W-1:0]  prd;
        logic [CHUNK-1:0] q;
        logic [DV_W-1:0]  back;
        v    = {rem_in, dig};
        prd  = DP_W'(v) * DP_W'(recip16(dvs));
        q    = prd[16 +: CHUNK];
        back = v - DV_W'(q) * DV_W'(dvs);
        return {back[REM_W-1:0], q};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/she_ser.sv -----
// Output serializer: takes a full row; one word per cycle while m_ready is high.
`default_nettype none

module she_ser
    import she_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ld_valid,
    output logic                               ld_ready,
    input  wire logic signed [VAL_W-1:0]       ld_vals [MAX_BANDS*MAX_BANDS],
    input  wire logic [$clog2(MAX_BANDS+1)-1:0] ld_bands,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output she_out_t                           m_data
);

    localparam int NV    = MAX_BANDS * MAX_BANDS;
    localparam int BW    = $clog2(MAX_BANDS + 1);
    localparam int CNT_W = (NV > 1) ? $clog2(NV) : 1;

    logic signed [VAL_W-1:0] sh_reg [NV];
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        last_reg;
    logic [CNT_W-1:0]        last_next;
    logic                    busy_reg;
    logic [2*BW-1:0]         sq;
    logic                    take;
    logic                    fin;
    logic                    load;

    assign take     = busy_reg && m_ready;
    assign fin      = take && (cnt_reg == last_reg);
    assign ld_ready = !busy_reg || fin;
    assign load     = ld_valid && ld_ready;
    assign sq       = (2*BW)'(ld_bands) * (2*BW)'(ld_bands);
    assign last_next = CNT_W'(sq - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            last_reg <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            last_reg <= last_next;
        end else if (take) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (fin) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < NV; k++) begin
                sh_reg[k] <= ld_vals[k];
            end
        end else if (take) begin
            for (int k = 0; k < NV - 1; k++) begin
                sh_reg[k] <= sh_reg[k+1];
            end
        end
    end

    assign m_valid           = busy_reg;
    assign m_data.coef_index = IDX_W'(cnt_reg);
    assign m_data.coef_value = sh_reg[0];
    assign m_data.last_coef  = (cnt_reg == last_reg);

endmodule

`default_nettype wire

// ----- rtl/sh_basis_eval_unit.sv -----
// Top level: spherical-harmonic basis pipeline, band configuration and output serializer.
//
//   port group   dir   word / purpose
//   s_*          in    she_in_t: one direction (dir_x, dir_y, dir_z)
//   m_*          out   she_out_t: one coefficient (coef_index, coef_value, last_coef)
//   APB          in    bands_in_use at byte 0
//
// One coefficient word per cycle at m_* while m_ready is high; a direction gives B*B words,
// so the output serializer, not the pipeline, sets the sustained rate of directions.
// Pipeline depth is 1 + (MAX_BANDS-1)*PH stages (40 at the default), one band row per PH stages.
// aresetn (sync, low) clears valid bits, the serializer and sets bands_in_use to 3.
// The whole pipeline holds only while its last stage is full and the serializer cannot take it.
`default_nettype none

module sh_basis_eval_unit
    import she_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire she_in_t           s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output she_out_t               m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int NV   = MAX_BANDS * MAX_BANDS;
    localparam int BW   = $clog2(MAX_BANDS + 1);
    localparam int NSTG = 1 + (MAX_BANDS - 1) * PH;

    typedef struct {
        logic signed [DIR_W-1:0]  x;
        logic signed [DIR_W-1:0]  y;
        logic signed [DIR_W-1:0]  z;
        logic signed [CS_W-1:0]   c    [MAX_BANDS];
        logic signed [CS_W-1:0]   s    [MAX_BANDS];
        logic signed [P_W-1:0]    p1   [MAX_BANDS];
        logic signed [P_W-1:0]    p2   [MAX_BANDS];
        logic signed [PROD_W-1:0] prod [MAX_BANDS];
        logic signed [NUM_W-1:0]  na   [MAX_BANDS];
        logic signed [NUM_W-1:0]  nb   [MAX_BANDS];
        logic [U_W-1:0]           u    [MAX_BANDS];
        logic [U_W-1:0]           q    [MAX_BANDS];
        logic [REM_W-1:0]         rem  [MAX_BANDS];
        logic                     neg  [MAX_BANDS];
        logic signed [MUL_W-1:0]  pc   [MAX_BANDS];
        logic signed [MUL_W-1:0]  ps   [MAX_BANDS];
        logic signed [CSP_W-1:0]  pxc;
        logic signed [CSP_W-1:0]  pys;
        logic signed [CSP_W-1:0]  pxs;
        logic signed [CSP_W-1:0]  pyc;
        logic signed [VAL_W-1:0]  vals [NV];
    } work_t;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] bands_reg;
    logic [BW-1:0]    bands_eff;
    logic             reg_sel;

    assign reg_sel = paddr[ADDR_W-1];
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == REG_BANDS) ? DATA_W'(bands_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bands_reg <= BANDS_RESET;
        end else if (psel && penable && pwrite && pready && (reg_sel == REG_BANDS)) begin
            bands_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (bands_reg == '0) begin
            bands_eff = BW'(1);
        end else if (int'(bands_reg) > MAX_BANDS) begin
            bands_eff = BW'(MAX_BANDS);
        end else begin
            bands_eff = BW'(bands_reg);
        end
    end

    // ---------------- pipeline ----------------
    work_t           stg_reg  [NSTG];
    work_t           stg_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            pipe_adv;
    logic            ser_ready;

    assign pipe_adv = !vld_reg[NSTG-1] || ser_ready;
    assign s_ready  = pipe_adv;

    always_comb begin
        vld_next[0] = s_valid;
        for (int g = 1; g < NSTG; g++) begin
            vld_next[g] = vld_reg[g-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            for (int g = 0; g < NSTG; g++) begin
                stg_reg[g] <= stg_next[g];
            end
        end
    end

    // entry: band 0 and the m=1 terms of (x+iy)^m
    always_comb begin
        work_t w;
        w = stg_reg[0];
        w.x = s_data.dir_x;
        w.y = s_data.dir_y;
        w.z = s_data.dir_z;
        for (int m = 0; m < MAX_BANDS; m++) begin
            w.c[m]  = (m == 1) ? CS_W'(s_data.dir_x) : '0;
            w.s[m]  = (m == 1) ? CS_W'(s_data.dir_y) : '0;
            w.p1[m] = (m == 0) ? pmm_q16(0) : '0;
            w.p2[m] = '0;
        end
        w.vals[0] = sat_val(MUL_W'(pmm_q16(0)));
        stg_next[0] = w;
    end

    for (genvar g = 1; g < NSTG; g++) begin : g_stg
        localparam int L   = (g - 1) / PH + 1;
        localparam int PHS = (g - 1) % PH;
        localparam int LN  = (L + 1 < MAX_BANDS) ? L + 1 : L;
        localparam int J   = (PHS >= 4) ? PHS - 4 : 0;

        case (PHS)
            0: begin : g_mul
                always_comb begin
                    work_t w;
                    w = stg_reg[g-1];
                    for (int m = 0; m < MAX_BANDS; m++) begin
                        if (m < L) begin
                            w.prod[m] = PROD_W'(w.z) * PROD_W'(w.p1[m]);
                        end
                    end
                    w.pxc = CSP_W'(w.x) * CSP_W'(w.c[L]);
                    w.pys = CSP_W'(w.y) * CSP_W'(w.s[L]);
                    w.pxs = CSP_W'(w.x) * CSP_W'(w.s[L]);
                    w.pyc = CSP_W'(w.y) * CSP_W'(w.c[L]);
                    stg_next[g] = w;
                end
            end
            1: begin : g_wgt
                always_comb begin
                    work_t w;
                    int    w2;
                    w = stg_reg[g-1];
                    for (int m = 0; m < MAX_BANDS; m++) begin
                        // first step above the sectoral term has no p2 term
                        w2 = (L == m + 1) ? 0 : L + m - 1;
                        if (m < L) begin
                            w.na[m] = NUM_W'(w.prod[m]) * NUM_W'(2 * L - 1);
                            w.nb[m] = NUM_W'(w.p2[m]) * NUM_W'(w2);
                        end
                    end
                    if (L + 1 < MAX_BANDS) begin
                        w.c[LN] = CS_W'(rnd15(RND_W'(w.pxc) - RND_W'(w.pys)));
                        w.s[LN] = CS_W'(rnd15(RND_W'(w.pxs) + RND_W'(w.pyc)));
                    end
                    stg_next[g] = w;
                end
            end
            2: begin : g_sub
                always_comb begin
                    work_t w;
                    w = stg_reg[g-1];
                    for (int m = 0; m < MAX_BANDS; m++) begin
                        if (m < L) begin
                            w.na[m] = w.na[m] - (w.nb[m] <<< 15);
                        end
                    end
                    stg_next[g] = w;
                end
            end
            3: begin : g_mag
                always_comb begin
                    work_t            w;
                    logic [NUM_W-1:0] mag;
                    int               kk;
                    w = stg_reg[g-1];
                    for (int m = 0; m < MAX_BANDS; m++) begin
                        kk  = (L == m + 1) ? 1 : L - m;
                        mag = w.na[m][NUM_W-1] ? NUM_W'(-w.na[m]) : NUM_W'(w.na[m]);
                        if (m < L) begin
                            w.neg[m] = w.na[m][NUM_W-1];
                            w.u[m]   = U_W'((mag + NUM_W'(kk * 16384)) >> 15);
                            w.rem[m] = '0;
                            w.q[m]   = '0;
                        end
                    end
                    stg_next[g] = w;
                end
            end
            PH - 3: begin : g_sgn
                always_comb begin
                    work_t                 w;
                    logic signed [P_W-1:0] qn;
                    w = stg_reg[g-1];
                    for (int m = 0; m < MAX_BANDS; m++) begin
                        qn = $signed(P_W'(w.q[m]));
                        if (m < L) begin
                            w.p2[m] = w.p1[m];
                            w.p1[m] = w.neg[m] ? -qn : qn;
                        end
                    end
                    w.p1[L] = pmm_q16(L);
                    w.p2[L] = '0;
                    stg_next[g] = w;
                end
            end
            PH - 2: begin : g_prd
                always_comb begin
                    work_t w;
                    w = stg_reg[g-1];
                    for (int m = 1; m < MAX_BANDS; m++) begin
                        if (m <= L) begin
                            w.pc[m] = MUL_W'(w.p1[m]) * MUL_W'(w.c[m]);
                            w.ps[m] = MUL_W'(w.p1[m]) * MUL_W'(w.s[m]);
                        end
                    end
                    stg_next[g] = w;
                end
            end
            PH - 1: begin : g_out
                always_comb begin
                    work_t w;
                    w = stg_reg[g-1];
                    w.vals[L*L+L] = sat_val(MUL_W'(w.p1[0]));
                    for (int m = 1; m < MAX_BANDS; m++) begin
                        if (m <= L) begin
                            w.vals[L*L+L+m] = sat_val(rnd15(RND_W'(w.pc[m])));
                            w.vals[L*L+L-m] = sat_val(rnd15(RND_W'(w.ps[m])));
                        end
                    end
                    stg_next[g] = w;
                end
            end
            default: begin : g_div
                // one byte of the quotient per stage, MSB first
                always_comb begin
                    work_t                  w;
                    logic [REM_W+CHUNK-1:0] dres;
                    int                     kk;
                    w = stg_reg[g-1];
                    for (int m = 0; m < MAX_BANDS; m++) begin
                        kk   = (L == m + 1) ? 1 : L - m;
                        dres = div_chunk(w.rem[m], w.u[m][U_W-1-CHUNK*J -: CHUNK], REM_W'(kk));
                        if (m < L) begin
                            w.rem[m] = dres[REM_W+CHUNK-1:CHUNK];
                            w.q[m][U_W-1-CHUNK*J -: CHUNK] = dres[CHUNK-1:0];
                        end
                    end
                    stg_next[g] = w;
                end
            end
        endcase
    end

    // ---------------- output ----------------
    she_ser #(
        .MAX_BANDS (MAX_BANDS)
    ) u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_valid (vld_reg[NSTG-1]),
        .ld_ready (ser_ready),
        .ld_vals  (stg_reg[NSTG-1].vals),
        .ld_bands (bands_eff),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTG-1] && !s_ready) |=> vld_reg[NSTG-1])
        else $error("last pipeline stage dropped a stalled word");

    a_first_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_coef) |=> (!m_valid || m_data.coef_index == '0))
        else $error("new direction does not start at coefficient zero");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_coef) |=>
            (m_valid && m_data.coef_index == IDX_W'($past(m_data.coef_index) + 4'd1)))
        else $error("coefficient index skipped or repeated");

endmodule

`default_nettype wire
